// ===== src/twdt_pkg.sv =====
// Shared types and constants for the time-window dedup table.
// No dependencies; imported by twdt_csr and time_window_dedup_table_unit.
package twdt_pkg;

   localparam int TABLE_SLOTS = 8192;
   localparam int MAX_PROBES = 64;
   localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
   localparam int PROBE_BITS = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

   localparam int KEY_BITS = 64;
   localparam int TIME_BITS = 64;
   localparam int ENTRY_BITS = KEY_BITS + TIME_BITS;

   localparam int WINDOW_BITS = 12;
   localparam int WINDOW_NS_BITS = 42;
   localparam logic [WINDOW_BITS-1:0] WINDOW_DEFAULT = 12'd30;
   localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = 12'd3600;
   localparam logic [WINDOW_NS_BITS-1:0] NS_PER_SEC = 42'd1000000000;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_WINDOW = 1'b0;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      OUT_CLAIMED   = 2'd0,
      OUT_DUP       = 2'd1,
      OUT_EXHAUSTED = 2'd2,
      OUT_CLEARED   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic                        opcode;
      logic [KEY_BITS-1:0]         event_key;
      logic signed [TIME_BITS-1:0] event_time;
   } req_type;

   typedef struct packed {
      logic                allow;
      logic [1:0]          outcome;
      logic [KEY_BITS-1:0] drop_total;
   } rsp_type;

endpackage

// ===== src/twdt_csr.sv =====
// Configuration register block: window_seconds with clamping, and the
// derived window in nanoseconds. Depends on twdt_pkg.
module twdt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [twdt_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [twdt_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [twdt_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic [twdt_pkg::WINDOW_NS_BITS-1:0]  window_span
);
   import twdt_pkg::*;

   logic [WINDOW_BITS-1:0]    window_ff;
   logic [WINDOW_BITS-1:0]    window_in;
   logic [WINDOW_NS_BITS-1:0] window_span_ff;
   logic [WINDOW_NS_BITS-1:0] window_span_in;
   logic [WINDOW_BITS-1:0]    wr_raw;
   logic [WINDOW_BITS-1:0]    wr_sat;
   logic                      wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
   assign wr_raw = pwdata[WINDOW_BITS-1:0];

   always_comb begin
      if (wr_raw == '0) begin
         wr_sat = WINDOW_DEFAULT;
      end else if (wr_raw > WINDOW_MAX) begin
         wr_sat = WINDOW_MAX;
      end else begin
         wr_sat = wr_raw;
      end
   end

   always_comb begin
      window_in = window_ff;
      window_span_in = window_span_ff;
      if (wr_hit) begin
         window_in = wr_sat;
         window_span_in = WINDOW_NS_BITS'(wr_sat) * NS_PER_SEC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_DEFAULT;
         window_span_ff <= WINDOW_NS_BITS'(WINDOW_DEFAULT) * NS_PER_SEC;
      end else begin
         window_ff <= window_in;
         window_span_ff <= window_span_in;
      end
   end

   assign prdata = (paddr[2] == REG_WINDOW) ? CSR_DATA_BITS'(window_ff) : '0;
   assign window_span = window_span_ff;

endmodule

// ===== src/time_window_dedup_table_unit.sv =====
// Time-window dedup table: linear-probe hash table with a shared compare unit.
// A check request steps through a read state and a compare state for each
// probe via the single read port; result strobes the cycle after the last compare.
// A clear request and the pass after reset sweep one slot per cycle with
// busy high; reset is synchronous, active high.
// Results are emitted for one cycle on rsp_valid and cannot be stalled.
module time_window_dedup_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  twdt_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   output twdt_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [twdt_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [twdt_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [twdt_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import twdt_pkg::*;

   logic [WINDOW_NS_BITS-1:0] window_span;

   state_type              state_ff, state_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [PROBE_BITS-1:0]  probe_ff, probe_in;
   logic [SLOT_BITS-1:0]   clr_idx_ff, clr_idx_in;
   logic                   clr_reply_ff, clr_reply_in;
   logic [KEY_BITS-1:0]    drop_ff, drop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [ENTRY_BITS-1:0]  rd_ff;

   logic [ENTRY_BITS-1:0]  mem [TABLE_SLOTS];
   logic                   mem_we;
   logic [SLOT_BITS-1:0]   mem_waddr;
   logic [ENTRY_BITS-1:0]  mem_wdata;

   logic [KEY_BITS-1:0]    rd_key;
   logic [TIME_BITS-1:0]   rd_time;
   logic [TIME_BITS-1:0]   age;
   logic                   slot_empty;
   logic                   slot_claim;
   logic                   slot_match;
   logic                   probe_last;
   logic                   clr_last;

   twdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .window_span (window_span)
   );

   assign rd_key = rd_ff[ENTRY_BITS-1:TIME_BITS];
   assign rd_time = rd_ff[TIME_BITS-1:0];
   assign age = now_ff - rd_time;
   assign slot_empty = (rd_key == '0) && (rd_time == '0);
   assign slot_claim = slot_empty || (age >= TIME_BITS'(window_span));
   assign slot_match = (rd_key == key_ff);
   assign probe_last = (probe_ff == PROBE_BITS'(MAX_PROBES - 1));
   assign clr_last = (clr_idx_ff == SLOT_BITS'(TABLE_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_payload.opcode == OP_CLEAR) ? ST_CLEAR : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_claim || slot_match || probe_last) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      key_in = key_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      probe_in = probe_ff;
      clr_idx_in = clr_idx_ff;
      clr_reply_in = clr_reply_ff;
      drop_in = drop_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = {key_ff, now_ff};
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_last) begin
               clr_reply_in = 1'b0;
               if (clr_reply_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.allow = 1'b0;
                  rsp_in.outcome = OUT_CLEARED;
                  rsp_in.drop_total = '0;
               end
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_payload.opcode == OP_CLEAR) begin
                  clr_idx_in = '0;
                  clr_reply_in = 1'b1;
                  drop_in = '0;
               end else begin
                  key_in = req_payload.event_key;
                  now_in = req_payload.event_time[TIME_BITS-1] ?
                           '0 : TIME_BITS'(req_payload.event_time);
                  idx_in = req_payload.event_key[SLOT_BITS-1:0];
                  probe_in = '0;
               end
            end
         end
         ST_READ: begin
         end
         ST_CHECK: begin
            if (slot_claim) begin
               mem_we = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.allow = 1'b1;
               rsp_in.outcome = OUT_CLAIMED;
               rsp_in.drop_total = drop_ff;
            end else if (slot_match) begin
               drop_in = drop_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.allow = 1'b0;
               rsp_in.outcome = OUT_DUP;
               rsp_in.drop_total = drop_ff + 1'b1;
            end else if (probe_last) begin
               rsp_valid_in = 1'b1;
               rsp_in.allow = 1'b1;
               rsp_in.outcome = OUT_EXHAUSTED;
               rsp_in.drop_total = drop_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_idx_ff <= '0;
         clr_reply_ff <= 1'b0;
         drop_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         clr_reply_ff <= clr_reply_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      now_ff <= now_in;
      idx_ff <= idx_in;
      probe_ff <= probe_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_CHECK || $past(state_ff) == ST_CLEAR))
      else $error("response without a check or clear step");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.outcome == OUT_CLEARED) |-> (drop_ff == '0))
      else $error("drop counter not zero after clear");

   a_allow_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.allow ==
         (rsp_payload.outcome == OUT_CLAIMED || rsp_payload.outcome == OUT_EXHAUSTED)))
      else $error("allow disagrees with outcome");

endmodule
